// File: rtl/swbc_pkg.sv
// Shared types, widths and codes for the swept box clearance pipeline.
package swbc_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int OFS_W   = 16;
    localparam int SIDE_W  = 16;

    // Internal widths: box corners, plane distances, ratio terms, products
    localparam int BOX_W  = COORD_W + 1;
    localparam int DIST_W = BOX_W + 1;
    localparam int FRAC_W = DIST_W + 1;
    localparam int PROD_W = 2 * FRAC_W;

    localparam int NUM_PLANES = 4;

    // Pipeline stage map
    localparam int NUM_STAGES = 9;
    localparam int STG_SUM    = 0;
    localparam int STG_DIST   = 1;
    localparam int STG_RATIO  = 2;
    localparam int STG_L1_MUL = 3;
    localparam int STG_L1_SEL = 4;
    localparam int STG_L2_MUL = 5;
    localparam int STG_L2_SEL = 6;
    localparam int STG_FIN    = 7;
    localparam int STG_OUT    = 8;

    typedef logic signed [BOX_W-1:0]  box_t;
    typedef logic signed [DIST_W-1:0] dist_t;
    typedef logic signed [FRAC_W-1:0] frac_val_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam frac_val_t FRAC_ONE       = frac_val_t'(1);
    localparam frac_val_t FRAC_MINUS_ONE = frac_val_t'(-1);

    // Ratio n/d with d always positive
    typedef struct packed {
        logic signed [FRAC_W-1:0] n;
        logic signed [FRAC_W-1:0] d;
    } frac_t;

    typedef frac_t [NUM_PLANES-1:0] frac_quad_t;

    typedef enum logic [1:0] {
        OUTCOME_CLEAR   = 2'd0,
        OUTCOME_BLOCKED = 2'd1,
        OUTCOME_INSIDE  = 2'd2
    } outcome_t;

    // Per-item status carried along with the ratios
    typedef struct packed {
        logic starts_out;
        logic hit;
    } flags_t;

    // Stage load strobes from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [OFS_W-1:0]   mover_min_x;
        logic signed [OFS_W-1:0]   mover_min_y;
        logic signed [OFS_W-1:0]   mover_max_x;
        logic signed [OFS_W-1:0]   mover_max_y;
        logic signed [COORD_W-1:0] obstacle_x;
        logic signed [COORD_W-1:0] obstacle_y;
        logic [SIDE_W-1:0]         obstacle_side;
    } sweep_word_t;

    typedef struct packed {
        logic     clear;
        outcome_t outcome;
    } result_word_t;

endpackage

// File: rtl/swbc_pipe_ctrl.sv
// Valid bits and bubble-collapsing stage strobes for the clearance pipeline.
module swbc_pipe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sweep_valid,
    output logic               sweep_stall,
    output logic               result_valid,
    input  logic               result_stall,
    output swbc_pkg::pipe_ctl_t ctl
);

    logic [swbc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [swbc_pkg::NUM_STAGES-1:0] ready;

    // A stage may load when it is empty or its word moves on
    always_comb
    begin
        ready[swbc_pkg::NUM_STAGES-1] = !valid_reg[swbc_pkg::NUM_STAGES-1] || !result_stall;
        for (int k = swbc_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign ctl.load     = ready;
    assign sweep_stall  = !ready[0];
    assign result_valid = valid_reg[swbc_pkg::NUM_STAGES-1];

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= sweep_valid;
            end
            for (int k = 1; k < swbc_pkg::NUM_STAGES; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Input backs up only when every stage holds a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_stall |-> (&valid_reg))
        else $error("input stalled while a stage is empty");

    // Free-running output never backs up the input
    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !sweep_stall)
        else $error("input stalled with output free");

    // An accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (sweep_valid && !sweep_stall) |=> valid_reg[0])
        else $error("accepted word lost at entry");

    // A held result word stays put
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("stalled result word dropped");

endmodule

// File: rtl/swbc_dist.sv
// Box corners, plane distances and per-plane entry and exit ratios.
module swbc_dist (
    input  logic                  clk,
    input  swbc_pkg::pipe_ctl_t   ctl,
    input  swbc_pkg::sweep_word_t sweep,
    output swbc_pkg::frac_quad_t  entry_frac,
    output swbc_pkg::frac_quad_t  exit_frac,
    output swbc_pkg::flags_t      flags
);

    // Stage: obstacle corners and mover corner positions
    logic [swbc_pkg::SIDE_W-2:0] half_side;
    logic [swbc_pkg::SIDE_W-1:0] ceil_side;
    swbc_pkg::box_t bmin_x_reg, bmax_x_reg, bmin_y_reg, bmax_y_reg;
    swbc_pkg::box_t shx_reg, slx_reg, ehx_reg, elx_reg;
    swbc_pkg::box_t shy_reg, sly_reg, ehy_reg, ely_reg;

    assign half_side = sweep.obstacle_side[swbc_pkg::SIDE_W-1:1];
    assign ceil_side = {1'b0, half_side} + swbc_pkg::SIDE_W'(sweep.obstacle_side[0]);

    always_ff @(posedge clk)
    begin
        if (ctl.load[swbc_pkg::STG_SUM])
        begin
            bmin_x_reg <= swbc_pkg::box_t'(sweep.obstacle_x) - swbc_pkg::box_t'(half_side);
            bmax_x_reg <= swbc_pkg::box_t'(sweep.obstacle_x) + swbc_pkg::box_t'(ceil_side);
            bmin_y_reg <= swbc_pkg::box_t'(sweep.obstacle_y) - swbc_pkg::box_t'(half_side);
            bmax_y_reg <= swbc_pkg::box_t'(sweep.obstacle_y) + swbc_pkg::box_t'(ceil_side);
            shx_reg <= swbc_pkg::box_t'(sweep.start_x) + swbc_pkg::box_t'(sweep.mover_max_x);
            slx_reg <= swbc_pkg::box_t'(sweep.start_x) + swbc_pkg::box_t'(sweep.mover_min_x);
            ehx_reg <= swbc_pkg::box_t'(sweep.end_x) + swbc_pkg::box_t'(sweep.mover_max_x);
            elx_reg <= swbc_pkg::box_t'(sweep.end_x) + swbc_pkg::box_t'(sweep.mover_min_x);
            shy_reg <= swbc_pkg::box_t'(sweep.start_y) + swbc_pkg::box_t'(sweep.mover_max_y);
            sly_reg <= swbc_pkg::box_t'(sweep.start_y) + swbc_pkg::box_t'(sweep.mover_min_y);
            ehy_reg <= swbc_pkg::box_t'(sweep.end_y) + swbc_pkg::box_t'(sweep.mover_max_y);
            ely_reg <= swbc_pkg::box_t'(sweep.end_y) + swbc_pkg::box_t'(sweep.mover_min_y);
        end
    end

    // Stage: signed distances, positive when outside the plane
    swbc_pkg::dist_t sd_reg [swbc_pkg::NUM_PLANES];
    swbc_pkg::dist_t ed_reg [swbc_pkg::NUM_PLANES];

    always_ff @(posedge clk)
    begin
        if (ctl.load[swbc_pkg::STG_DIST])
        begin
            // left, right, bottom, top
            sd_reg[0] <= swbc_pkg::dist_t'(bmin_x_reg) - swbc_pkg::dist_t'(shx_reg);
            ed_reg[0] <= swbc_pkg::dist_t'(bmin_x_reg) - swbc_pkg::dist_t'(ehx_reg);
            sd_reg[1] <= swbc_pkg::dist_t'(slx_reg) - swbc_pkg::dist_t'(bmax_x_reg);
            ed_reg[1] <= swbc_pkg::dist_t'(elx_reg) - swbc_pkg::dist_t'(bmax_x_reg);
            sd_reg[2] <= swbc_pkg::dist_t'(bmin_y_reg) - swbc_pkg::dist_t'(shy_reg);
            ed_reg[2] <= swbc_pkg::dist_t'(bmin_y_reg) - swbc_pkg::dist_t'(ehy_reg);
            sd_reg[3] <= swbc_pkg::dist_t'(sly_reg) - swbc_pkg::dist_t'(bmax_y_reg);
            ed_reg[3] <= swbc_pkg::dist_t'(ely_reg) - swbc_pkg::dist_t'(bmax_y_reg);
        end
    end

    // Stage: entry ratio and negated exit ratio per plane, idle planes get -1
    swbc_pkg::frac_quad_t entry_next, exit_next, entry_reg, exit_reg;
    swbc_pkg::flags_t     flags_next, flags_reg;
    logic [swbc_pkg::NUM_PLANES-1:0] s_out, e_out;

    always_comb
    begin
        for (int i = 0; i < swbc_pkg::NUM_PLANES; i++)
        begin
            s_out[i] = !sd_reg[i][swbc_pkg::DIST_W-1] && (sd_reg[i] != '0);
            e_out[i] = !ed_reg[i][swbc_pkg::DIST_W-1] && (ed_reg[i] != '0);
            if (s_out[i] && !e_out[i])
            begin
                entry_next[i].n = swbc_pkg::frac_val_t'(sd_reg[i]) - swbc_pkg::FRAC_ONE;
                entry_next[i].d = swbc_pkg::frac_val_t'(sd_reg[i])
                                  - swbc_pkg::frac_val_t'(ed_reg[i]);
            end
            else
            begin
                entry_next[i].n = swbc_pkg::FRAC_MINUS_ONE;
                entry_next[i].d = swbc_pkg::FRAC_ONE;
            end
            // exit ratio is -(sd+1)/(ed-sd); keep its negation for a max search
            if (!s_out[i] && e_out[i])
            begin
                exit_next[i].n = swbc_pkg::frac_val_t'(sd_reg[i]) + swbc_pkg::FRAC_ONE;
                exit_next[i].d = swbc_pkg::frac_val_t'(ed_reg[i])
                                 - swbc_pkg::frac_val_t'(sd_reg[i]);
            end
            else
            begin
                exit_next[i].n = swbc_pkg::FRAC_MINUS_ONE;
                exit_next[i].d = swbc_pkg::FRAC_ONE;
            end
        end
        flags_next.starts_out = |s_out;
        flags_next.hit        = |(s_out & e_out);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[swbc_pkg::STG_RATIO])
        begin
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
            flags_reg <= flags_next;
        end
    end

    assign entry_frac = entry_reg;
    assign exit_frac  = exit_reg;
    assign flags      = flags_reg;

endmodule

// File: rtl/swbc_frac_max.sv
// Two-stage exact compare of two ratios by cross-multiplication; keeps the larger.
module swbc_frac_max (
    input  logic            clk,
    input  logic            load_mul,
    input  logic            load_sel,
    input  swbc_pkg::frac_t a,
    input  swbc_pkg::frac_t b,
    output swbc_pkg::frac_t larger
);

    swbc_pkg::frac_t a_reg, b_reg, win_reg;
    swbc_pkg::prod_t pab_reg, pba_reg;

    // Cross products: a < b exactly when a.n*b.d < b.n*a.d
    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            a_reg   <= a;
            b_reg   <= b;
            pab_reg <= swbc_pkg::prod_t'(a.n) * swbc_pkg::prod_t'(b.d);
            pba_reg <= swbc_pkg::prod_t'(b.n) * swbc_pkg::prod_t'(a.d);
        end
    end

    // Select; equal ratios keep a
    always_ff @(posedge clk)
    begin
        if (load_sel)
        begin
            win_reg <= (pab_reg < pba_reg) ? b_reg : a_reg;
        end
    end

    assign larger = win_reg;

endmodule

// File: rtl/swbc_rank_tree.sv
// Two-level registered max tree over plane entry ratios and negated exit ratios.
module swbc_rank_tree (
    input  logic                 clk,
    input  swbc_pkg::pipe_ctl_t  ctl,
    input  swbc_pkg::frac_quad_t entry_frac,
    input  swbc_pkg::frac_quad_t exit_frac,
    input  swbc_pkg::flags_t     flags_in,
    output swbc_pkg::frac_t      start_frac,
    output swbc_pkg::frac_t      neg_stop_frac,
    output swbc_pkg::flags_t     flags_out
);

    swbc_pkg::frac_t ent_lo, ent_hi, ext_lo, ext_hi;

    // First level: planes paired x and y
    swbc_frac_max u_ent_x (
        .clk      (clk),
        .load_mul (ctl.load[swbc_pkg::STG_L1_MUL]),
        .load_sel (ctl.load[swbc_pkg::STG_L1_SEL]),
        .a        (entry_frac[0]),
        .b        (entry_frac[1]),
        .larger   (ent_lo)
    );

    swbc_frac_max u_ent_y (
        .clk      (clk),
        .load_mul (ctl.load[swbc_pkg::STG_L1_MUL]),
        .load_sel (ctl.load[swbc_pkg::STG_L1_SEL]),
        .a        (entry_frac[2]),
        .b        (entry_frac[3]),
        .larger   (ent_hi)
    );

    swbc_frac_max u_ext_x (
        .clk      (clk),
        .load_mul (ctl.load[swbc_pkg::STG_L1_MUL]),
        .load_sel (ctl.load[swbc_pkg::STG_L1_SEL]),
        .a        (exit_frac[0]),
        .b        (exit_frac[1]),
        .larger   (ext_lo)
    );

    swbc_frac_max u_ext_y (
        .clk      (clk),
        .load_mul (ctl.load[swbc_pkg::STG_L1_MUL]),
        .load_sel (ctl.load[swbc_pkg::STG_L1_SEL]),
        .a        (exit_frac[2]),
        .b        (exit_frac[3]),
        .larger   (ext_hi)
    );

    // Second level
    swbc_frac_max u_ent_all (
        .clk      (clk),
        .load_mul (ctl.load[swbc_pkg::STG_L2_MUL]),
        .load_sel (ctl.load[swbc_pkg::STG_L2_SEL]),
        .a        (ent_lo),
        .b        (ent_hi),
        .larger   (start_frac)
    );

    swbc_frac_max u_ext_all (
        .clk      (clk),
        .load_mul (ctl.load[swbc_pkg::STG_L2_MUL]),
        .load_sel (ctl.load[swbc_pkg::STG_L2_SEL]),
        .a        (ext_lo),
        .b        (ext_hi),
        .larger   (neg_stop_frac)
    );

    // Carry status flags alongside the tree
    swbc_pkg::flags_t flags_reg [4];

    always_ff @(posedge clk)
    begin
        if (ctl.load[swbc_pkg::STG_L1_MUL])
        begin
            flags_reg[0] <= flags_in;
        end
        if (ctl.load[swbc_pkg::STG_L1_SEL])
        begin
            flags_reg[1] <= flags_reg[0];
        end
        if (ctl.load[swbc_pkg::STG_L2_MUL])
        begin
            flags_reg[2] <= flags_reg[1];
        end
        if (ctl.load[swbc_pkg::STG_L2_SEL])
        begin
            flags_reg[3] <= flags_reg[2];
        end
    end

    assign flags_out = flags_reg[3];

endmodule

// File: rtl/swbc_decide.sv
// Final window test on the start and stop ratios and the result word register.
module swbc_decide (
    input  logic                   clk,
    input  swbc_pkg::pipe_ctl_t    ctl,
    input  swbc_pkg::frac_t        start_frac,
    input  swbc_pkg::frac_t        neg_stop_frac,
    input  swbc_pkg::flags_t       flags_in,
    output swbc_pkg::result_word_t result
);

    localparam int SUM_W = swbc_pkg::PROD_W + 1;
    typedef logic signed [SUM_W-1:0] wsum_t;
    typedef logic signed [swbc_pkg::FRAC_W:0] start_sum_t;

    swbc_pkg::prod_t  p_start_reg, p_stop_reg;
    logic             past_start_reg;
    swbc_pkg::flags_t flags_reg;
    start_sum_t       start_sum;

    // start > -1 exactly when n + d > 0
    assign start_sum = start_sum_t'(start_frac.n) + start_sum_t'(start_frac.d);

    // Cross products for start < stop, with stop = -neg_stop
    always_ff @(posedge clk)
    begin
        if (ctl.load[swbc_pkg::STG_FIN])
        begin
            p_start_reg    <= swbc_pkg::prod_t'(start_frac.n)
                              * swbc_pkg::prod_t'(neg_stop_frac.d);
            p_stop_reg     <= swbc_pkg::prod_t'(neg_stop_frac.n)
                              * swbc_pkg::prod_t'(start_frac.d);
            past_start_reg <= !start_sum[swbc_pkg::FRAC_W] && (start_sum != '0);
            flags_reg      <= flags_in;
        end
    end

    // Classify and hold the result word
    wsum_t                  window_sum;
    logic                   blocked;
    swbc_pkg::result_word_t result_next, result_reg;

    assign window_sum = wsum_t'(p_start_reg) + wsum_t'(p_stop_reg);
    assign blocked    = window_sum[SUM_W-1] && past_start_reg;

    always_comb
    begin
        priority if (flags_reg.hit)
        begin
            result_next.clear   = 1'b1;
            result_next.outcome = swbc_pkg::OUTCOME_CLEAR;
        end
        else if (!flags_reg.starts_out)
        begin
            result_next.clear   = 1'b0;
            result_next.outcome = swbc_pkg::OUTCOME_INSIDE;
        end
        else if (blocked)
        begin
            result_next.clear   = 1'b0;
            result_next.outcome = swbc_pkg::OUTCOME_BLOCKED;
        end
        else
        begin
            result_next.clear   = 1'b1;
            result_next.outcome = swbc_pkg::OUTCOME_CLEAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[swbc_pkg::STG_OUT])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/swept_box_vs_box_clearance.sv
// Top level of the swept box against square obstacle clearance pipeline.
//
// Usage:
//   sweep channel: one word per query holds the mover's start and end point,
//   its box offsets, and the obstacle's center and side. It is taken at a
//   rising edge with sweep_valid high and sweep_stall low.
//   result channel: one word per query, in query order, with clear and the
//   outcome code (clear, blocked part way, starts inside). It is taken at a
//   rising edge with result_valid high and result_stall low.
// Throughput: one query per cycle while the result channel does not stall.
//   The nine register stages are corners, distances, ratios, two compare
//   levels of a max tree (multiply, select each), and the final
//   cross-multiply window test with its output register.
// Stall: each stage loads when it is empty or its word moves on, so bubbles
//   close up behind a stalled result word and the input keeps taking words
//   until every stage is full; then sweep_stall rises. Nothing is lost.
// Reset: rst_n clears all valid bits; the data registers are not reset.
module swept_box_vs_box_clearance (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sweep_valid,
    output logic                   sweep_stall,
    input  swbc_pkg::sweep_word_t  sweep,
    output logic                   result_valid,
    input  logic                   result_stall,
    output swbc_pkg::result_word_t result
);

    swbc_pkg::pipe_ctl_t  ctl;
    swbc_pkg::frac_quad_t entry_frac, exit_frac;
    swbc_pkg::flags_t     dist_flags, tree_flags;
    swbc_pkg::frac_t      start_frac, neg_stop_frac;

    swbc_pipe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sweep_valid  (sweep_valid),
        .sweep_stall  (sweep_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctl          (ctl)
    );

    swbc_dist u_dist (
        .clk        (clk),
        .ctl        (ctl),
        .sweep      (sweep),
        .entry_frac (entry_frac),
        .exit_frac  (exit_frac),
        .flags      (dist_flags)
    );

    swbc_rank_tree u_tree (
        .clk           (clk),
        .ctl           (ctl),
        .entry_frac    (entry_frac),
        .exit_frac     (exit_frac),
        .flags_in      (dist_flags),
        .start_frac    (start_frac),
        .neg_stop_frac (neg_stop_frac),
        .flags_out     (tree_flags)
    );

    swbc_decide u_decide (
        .clk           (clk),
        .ctl           (ctl),
        .start_frac    (start_frac),
        .neg_stop_frac (neg_stop_frac),
        .flags_in      (tree_flags),
        .result        (result)
    );

endmodule

// File: bench/tb.sv
// Testbench for the swept box against square obstacle clearance pipeline.
module tb;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RANDOM_WORDS  = 1450;
    localparam int  PHASE_WORDS   = 150;
    localparam int  HOLD_CYCLES   = 60;
    localparam int  DRAIN_CYCLES  = 20;
    localparam longint PLANE_MARGIN = 1;

    // Idle patterns applied to the two channels
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Predicts the clearance verdict of each accepted sweep and checks results in order
    class clearance_scoreboard;
        swbc_pkg::result_word_t verdict_q[$];
        int errors;

        function swbc_pkg::result_word_t predict_clearance(swbc_pkg::sweep_word_t w);
            longint sx, sy, ex, ey, mnx, mny, mxx, mxy, ox, oy, side, half;
            longint bminx, bminy, bmaxx, bmaxy;
            longint sd_a[4];
            longint ed_a[4];
            longint st_n, st_d, en_n, en_d, n, d, sd, ed;
            bit starts_out;
            swbc_pkg::result_word_t r;
            sx = w.start_x;
            sy = w.start_y;
            ex = w.end_x;
            ey = w.end_y;
            mnx = w.mover_min_x;
            mny = w.mover_min_y;
            mxx = w.mover_max_x;
            mxy = w.mover_max_y;
            ox = w.obstacle_x;
            oy = w.obstacle_y;
            side = w.obstacle_side;
            half = side / 2;
            bminx = ox - half;
            bminy = oy - half;
            bmaxx = bminx + side;
            bmaxy = bminy + side;
            // Distances outside left, right, bottom, top planes
            sd_a[0] = bminx - (sx + mxx);
            ed_a[0] = bminx - (ex + mxx);
            sd_a[1] = (sx + mnx) - bmaxx;
            ed_a[1] = (ex + mnx) - bmaxx;
            sd_a[2] = bminy - (sy + mxy);
            ed_a[2] = bminy - (ey + mxy);
            sd_a[3] = (sy + mny) - bmaxy;
            ed_a[3] = (ey + mny) - bmaxy;
            st_n = -1;
            st_d = 1;
            en_n = 1;
            en_d = 1;
            starts_out = 1'b0;
            r.clear = 1'b1;
            r.outcome = swbc_pkg::OUTCOME_CLEAR;
            for (int p = 0; p < swbc_pkg::NUM_PLANES; p++)
            begin
                sd = sd_a[p];
                ed = ed_a[p];
                if (sd > 0)
                    starts_out = 1'b1;
                if (sd > 0 && ed > 0)
                    return r;
                if (sd <= 0 && ed <= 0)
                    continue;
                if (sd > ed)
                begin
                    // Entering: raise the entry ratio only when strictly larger
                    n = sd - PLANE_MARGIN;
                    d = sd - ed;
                    if (st_n * d < n * st_d)
                    begin
                        st_n = n;
                        st_d = d;
                    end
                end
                else
                begin
                    // Leaving: lower the exit ratio only when strictly smaller
                    n = -(sd + PLANE_MARGIN);
                    d = ed - sd;
                    if (n * en_d < en_n * d)
                    begin
                        en_n = n;
                        en_d = d;
                    end
                end
            end
            if (!starts_out)
            begin
                r.clear = 1'b0;
                r.outcome = swbc_pkg::OUTCOME_INSIDE;
            end
            else if (st_n * en_d < en_n * st_d && -st_d < st_n)
            begin
                r.clear = 1'b0;
                r.outcome = swbc_pkg::OUTCOME_BLOCKED;
            end
            return r;
        endfunction

        function void note_sweep(swbc_pkg::sweep_word_t w);
            verdict_q.insert(verdict_q.size(), predict_clearance(w));
        endfunction

        function void check_result(swbc_pkg::result_word_t r);
            swbc_pkg::result_word_t want;
            if (verdict_q.size() == 0)
            begin
                $error("result word with no sweep pending: clear=%0d outcome=%0d",
                       r.clear, r.outcome);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            if (r.clear !== want.clear)
            begin
                $error("clear: expected %0d, got %0d", want.clear, r.clear);
                errors++;
            end
            if (r.outcome !== want.outcome)
            begin
                $error("outcome: expected %0d, got %0d", want.outcome, r.outcome);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   sweep_valid = 1'b0;
    logic                   sweep_stall;
    swbc_pkg::sweep_word_t  sweep = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    swbc_pkg::result_word_t result;

    clearance_scoreboard sb = new();
    idle_mode_t idle_mode = IDLE_NONE;
    bit         hold_pending = 1'b0;
    int         hold_left = 0;

    swept_box_vs_box_clearance uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sweep_valid  (sweep_valid),
        .sweep_stall  (sweep_stall),
        .sweep        (sweep),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SENDER: return chance(78);
            IDLE_BOTH:   return chance(13);
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_mode)
            IDLE_RECEIVER: return chance(78);
            IDLE_BOTH:     return chance(13);
            default:       return 1'b0;
        endcase
    endfunction

    function automatic swbc_pkg::sweep_word_t make_sweep(int sx, int sy, int ex, int ey,
                                                        int mnx, int mny, int mxx, int mxy,
                                                        int ox, int oy, int side);
        swbc_pkg::sweep_word_t w;
        w.start_x = sx[swbc_pkg::COORD_W-1:0];
        w.start_y = sy[swbc_pkg::COORD_W-1:0];
        w.end_x = ex[swbc_pkg::COORD_W-1:0];
        w.end_y = ey[swbc_pkg::COORD_W-1:0];
        w.mover_min_x = mnx[swbc_pkg::OFS_W-1:0];
        w.mover_min_y = mny[swbc_pkg::OFS_W-1:0];
        w.mover_max_x = mxx[swbc_pkg::OFS_W-1:0];
        w.mover_max_y = mxy[swbc_pkg::OFS_W-1:0];
        w.obstacle_x = ox[swbc_pkg::COORD_W-1:0];
        w.obstacle_y = oy[swbc_pkg::COORD_W-1:0];
        w.obstacle_side = side[swbc_pkg::SIDE_W-1:0];
        return w;
    endfunction

    function automatic int offset_within(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly sweeps aimed around the obstacle, with some raw noise words
    function automatic swbc_pkg::sweep_word_t random_sweep();
        swbc_pkg::sweep_word_t w;
        int ox, oy, side, spread, reach;
        if (chance(12))
        begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return w;
        end
        ox = offset_within(8388607);
        oy = offset_within(8388607);
        side = chance(20) ? int'($urandom_range(65535)) : int'($urandom_range(64));
        case ($urandom_range(9))
            0, 1, 2: spread = side + 8;
            3, 4, 5: spread = 4 * side + 64;
            6, 7:    spread = 65536;
            8:       spread = 1024;
            default: spread = 4194304;
        endcase
        reach = chance(15) ? 32767 : side / 2 + 4;
        if (chance(10))
            return make_sweep(ox + offset_within(spread), oy + offset_within(spread),
                              ox + offset_within(spread), oy + offset_within(spread),
                              int'($urandom), int'($urandom), int'($urandom),
                              int'($urandom), ox, oy, side);
        return make_sweep(ox + offset_within(spread), oy + offset_within(spread),
                          ox + offset_within(spread), oy + offset_within(spread),
                          -int'($urandom_range(reach)), -int'($urandom_range(reach)),
                          int'($urandom_range(reach)), int'($urandom_range(reach)),
                          ox, oy, side);
    endfunction

    // Offer one word, resting first as the idle mode asks; return once it is taken
    task automatic send_sweep(input swbc_pkg::sweep_word_t w);
        while (sender_rests())
        begin
            @(negedge clk);
            sweep_valid <= 1'b0;
        end
        @(negedge clk);
        sweep_valid <= 1'b1;
        sweep <= w;
        do
            @(posedge clk);
        while (sweep_stall);
        sb.note_sweep(w);
    endtask

    task automatic run_directed();
        // Box of side 100 at the origin spans -50..50 on both axes
        send_sweep(make_sweep(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100));
        send_sweep(make_sweep(-200, 0, -150, 0, -5, -5, 5, 5, 0, 0, 100));
        send_sweep(make_sweep(-200, 0, 200, 0, -5, -5, 5, 5, 0, 0, 100));
        // Ends exactly on the left plane
        send_sweep(make_sweep(-200, 0, -55, 0, -5, -5, 5, 5, 0, 0, 100));
        // Starts one unit outside, entry ratio zero
        send_sweep(make_sweep(-56, 0, 100, 0, -5, -5, 5, 5, 0, 0, 100));
        // Starts touching the plane, so inside
        send_sweep(make_sweep(-55, 0, 100, 0, -5, -5, 5, 5, 0, 0, 100));
        // Rises over the top plane before reaching the left one, so clear
        send_sweep(make_sweep(-100, 0, 100, 300, -5, -5, 5, 5, 0, 0, 100));
        send_sweep(make_sweep(-200, -100, 100, 200, -5, -5, 5, 5, 0, 0, 100));
        send_sweep(make_sweep(-200, 200, 200, -100, -5, -5, 5, 5, 0, 0, 100));
        // Degenerate and odd sides
        send_sweep(make_sweep(-10, 0, 10, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sweep(make_sweep(-10, 0, 10, 0, 0, 0, 0, 0, 0, 0, 1));
        send_sweep(make_sweep(-70000, 5, 70000, 5, -3, -3, 3, 3, 0, 0, 65535));
        // Field extremes
        send_sweep(make_sweep(-8388608, -8388608, 8388607, 8388607,
                              -32768, -32768, 32767, 32767, 0, 0, 65535));
        send_sweep(make_sweep(8388607, 8388607, 8388607, 8388607,
                              32767, 32767, 32767, 32767, 8388607, 8388607, 65535));
        send_sweep(make_sweep(-8388608, -8388608, -8388608, -8388608,
                              -32768, -32768, -32768, -32768, -8388608, -8388608, 0));
        send_sweep(make_sweep(8388000, -8388000, 8388607, -8388608,
                              -100, -100, 100, 100, 8388607, -8388608, 65535));
        // Inverted mover box, zero-length sweep, leaving the obstacle
        send_sweep(make_sweep(-200, 0, 200, 0, 20, 20, -20, -20, 0, 0, 100));
        send_sweep(make_sweep(300, 300, 300, 300, -5, -5, 5, 5, 0, 0, 100));
        send_sweep(make_sweep(0, 0, 300, 0, -5, -5, 5, 5, 0, 0, 100));
        // Other directions of approach
        send_sweep(make_sweep(0, -300, 0, 300, -5, -5, 5, 5, 0, 0, 100));
        send_sweep(make_sweep(300, 10, -300, 10, -5, -5, 5, 5, 0, 0, 100));
        send_sweep(make_sweep(0, 300, 0, 0, -5, -5, 5, 5, 0, 0, 100));
    endtask

    // Drive result_stall: idle-mode stalls, plus long hold-offs on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_pending)
            begin
                hold_left = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= receiver_rests();
        end
    end

    // Check each result word taken at a rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    // Run limit
    initial
    begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

    // Reset, directed words, random words by idle phase, drain
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            idle_mode = idle_mode_t'((i / PHASE_WORDS) % 4);
            if (i == 40 || i == 640)
                hold_pending = 1'b1;
            send_sweep(random_sweep());
        end
        @(negedge clk);
        sweep_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
